// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the checker files of this block
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== hw/rtl/mhc_pkg.sv =====
// shared types and constants of the magnetometer heading block
// no dependencies; used by every module of the block
package mhc_pkg;

    // input commands
    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_START  = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_ABORT  = 2'd3
    } action_t;

    // calibration outcome
    typedef enum logic [1:0] {
        STAT_NONE      = 2'd0,
        STAT_ACCEPTED  = 2'd1,
        STAT_TOO_SMALL = 2'd2
    } cal_status_t;

    // configuration register indexes
    typedef enum logic {
        REG_MIN_SPAN    = 1'b0,
        REG_DECLINATION = 1'b1
    } reg_index_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_CORDIC = 2'd1,
        ST_DONE   = 2'd2
    } state_t;

    // datapath widths
    localparam int DIFF_W   = 17;            // offset-corrected axis value
    localparam int FRAC_W   = 20;            // fraction bits of the rotating vector
    localparam int CORDIC_W = 40;            // rotating vector, covers the CORDIC gain
    localparam int ANGLE_W  = 18;            // angle accumulator, 1/256 degree
    localparam int HEAD_W   = ANGLE_W + 1;   // angle plus declination
    localparam int TURN_W   = 17;            // wrapped angle 0..FULL_TURN-1
    localparam int TABLE_LEN = 24;

    // angle constants in 1/256 degree
    localparam int FULL_TURN    = 92160;
    localparam int QUARTER_TURN = 23040;
    localparam int ROUND_HALF   = 128;

    // degree constants
    localparam int DEG_TURN    = 360;
    localparam int CARD_BIAS   = 22;
    localparam int CARD_SECTOR = 45;
    localparam int CARD_POINTS = 8;

    localparam logic [15:0] MIN_SPAN_RESET = 16'd500;

    // atan(2^-i) in 1/256 degree, rounded to nearest
    localparam logic [ANGLE_W-1:0] STEP_ANGLE [TABLE_LEN] = '{
        18'd11520, 18'd6801, 18'd3593, 18'd1824, 18'd916, 18'd458, 18'd229, 18'd115,
        18'd57,    18'd29,   18'd14,   18'd7,    18'd4,   18'd2,   18'd1,   18'd0,
        18'd0,     18'd0,    18'd0,    18'd0,    18'd0,   18'd0,   18'd0,   18'd0
    };

    // vector handed from cell to cell
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANGLE_W-1:0]  z;
    } cordic_vec_t;

endpackage

// ===== hw/rtl/magnetometer_heading_hard_iron_cal.sv =====
// top level of the magnetometer heading block with hard-iron calibration
// depends on mhc_pkg, mhc_cordic_cell and mhc_heading_post
//
// Each request carries a command in s_tuser (sample, start, finish or abort
// calibration) and one raw X/Y reading in s_tdata, and gives exactly one
// result on the m side. A sample widens the min/max trackers while
// calibrating, subtracts the hard-iron offsets, and runs atan2 through a
// chain of ITERATIONS CORDIC cells, one micro-rotation per cell per clock;
// declination, wrap, rounding and the cardinal index follow in one more
// stage. A sample passes the entry register, the cell chain, the post
// stage register and the DONE state on its way to the output register;
// start, finish and abort pass only the DONE state. The block returns to
// idle as the result is written to the output register; DONE waits while
// an earlier result is still stalled there. One request is in flight at a
// time; the next is taken as soon as the previous result is in the output
// register, even while that result still waits. The configuration port
// writes min_span (index 0) and the signed declination in whole degrees
// (index 1, low 9 bits) and must be used while idle.
module magnetometer_heading_hard_iron_cal
    import mhc_pkg::*;
#(
    parameter int ITERATIONS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // raw_x [15:0], raw_y [31:16]
    input  logic [1:0]  s_tuser,   // action [1:0]
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // heading [8:0], cardinal [11:9], calibrating [12],
                                   // cal_status [14:13], span [30:15], offset_x [46:31],
                                   // offset_y [62:47], zero [63]
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    // architectural state
    state_t             state_reg, state_next;
    logic               cal_active_reg, cal_active_next;
    logic signed [15:0] min_x_reg, min_x_next;
    logic signed [15:0] max_x_reg, max_x_next;
    logic signed [15:0] min_y_reg, min_y_next;
    logic signed [15:0] max_y_reg, max_y_next;
    logic signed [15:0] off_x_reg, off_x_next;
    logic signed [15:0] off_y_reg, off_y_next;
    cal_status_t        last_result_reg, last_result_next;
    logic [8:0]         last_heading_reg, last_heading_next;
    logic [2:0]         last_cardinal_reg, last_cardinal_next;
    logic [15:0]        min_span_reg, min_span_next;
    logic signed [8:0]  decl_reg, decl_next;

    // chain entry and output register
    logic               entry_valid_reg, entry_valid_next;
    cordic_vec_t        entry_vec_reg, entry_vec_next;
    logic               zero_reg, zero_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [63:0]        m_tdata_reg, m_tdata_next;

    // request decode
    logic               accept;
    action_t            action;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] px;
    logic signed [DIFF_W-1:0] py;
    logic signed [ANGLE_W-1:0] pz;

    // calibration arithmetic
    logic signed [DIFF_W-1:0] sx;
    logic signed [DIFF_W-1:0] sy;
    logic signed [DIFF_W-1:0] smax;
    logic [15:0]              span_val;
    logic signed [DIFF_W-1:0] sum_x;
    logic signed [DIFF_W-1:0] sum_y;
    logic signed [DIFF_W-1:0] adj_x;
    logic signed [DIFF_W-1:0] adj_y;
    logic                     span_small;

    // cell chain
    cordic_vec_t              chain_vec   [ITERATIONS+1];
    logic [ITERATIONS:0]      chain_valid;
    logic                     post_valid;
    logic [8:0]               post_heading;
    logic [2:0]               post_cardinal;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign action   = action_t'(s_tuser);
    assign raw_x    = $signed(s_tdata[15:0]);
    assign raw_y    = $signed(s_tdata[31:16]);

    // offset-corrected axes in 17 bits so the difference cannot wrap
    assign dx = $signed({raw_x[15], raw_x}) - $signed({off_x_reg[15], off_x_reg});
    assign dy = $signed({raw_y[15], raw_y}) - $signed({off_y_reg[15], off_y_reg});

    // pre-rotation into the right half plane
    always_comb
    begin
        if (dx[DIFF_W-1])
        begin
            if (!dy[DIFF_W-1])
            begin
                px = dy;
                py = -dx;
                pz = ANGLE_W'(QUARTER_TURN);
            end
            else
            begin
                px = -dy;
                py = dx;
                pz = -ANGLE_W'(QUARTER_TURN);
            end
        end
        else
        begin
            px = dx;
            py = dy;
            pz = '0;
        end
    end

    // swings and midpoints of the trackers
    assign sx    = $signed({max_x_reg[15], max_x_reg}) - $signed({min_x_reg[15], min_x_reg});
    assign sy    = $signed({max_y_reg[15], max_y_reg}) - $signed({min_y_reg[15], min_y_reg});
    assign smax  = (sx > sy) ? sx : sy;
    assign span_val = smax[DIFF_W-1] ? 16'd0 : smax[15:0];
    assign sum_x = $signed({max_x_reg[15], max_x_reg}) + $signed({min_x_reg[15], min_x_reg});
    assign sum_y = $signed({max_y_reg[15], max_y_reg}) + $signed({min_y_reg[15], min_y_reg});
    // add one to a negative sum so the halving truncates toward zero
    assign adj_x = sum_x + $signed({{(DIFF_W-1){1'b0}}, sum_x[DIFF_W-1]});
    assign adj_y = sum_y + $signed({{(DIFF_W-1){1'b0}}, sum_y[DIFF_W-1]});
    assign span_small = (sx[DIFF_W-1] || (sx[15:0] < min_span_reg))
                     && (sy[DIFF_W-1] || (sy[15:0] < min_span_reg));

    // sequencer, calibration commands and configuration writes
    always_comb
    begin
        state_next         = state_reg;
        cal_active_next    = cal_active_reg;
        min_x_next         = min_x_reg;
        max_x_next         = max_x_reg;
        min_y_next         = min_y_reg;
        max_y_next         = max_y_reg;
        off_x_next         = off_x_reg;
        off_y_next         = off_y_reg;
        last_result_next   = last_result_reg;
        last_heading_next  = last_heading_reg;
        last_cardinal_next = last_cardinal_reg;
        min_span_next      = min_span_reg;
        decl_next          = decl_reg;
        entry_valid_next   = 1'b0;
        entry_vec_next     = entry_vec_reg;
        zero_next          = zero_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        m_tdata_next       = m_tdata_reg;

        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_SPAN:    min_span_next = cfg_data;
                REG_DECLINATION: decl_next     = $signed(cfg_data[8:0]);
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DONE;
                    unique case (action)
                        ACT_SAMPLE:
                        begin
                            if (cal_active_reg)
                            begin
                                if (raw_x < min_x_reg) min_x_next = raw_x;
                                if (raw_x > max_x_reg) max_x_next = raw_x;
                                if (raw_y < min_y_reg) min_y_next = raw_y;
                                if (raw_y > max_y_reg) max_y_next = raw_y;
                            end
                            entry_valid_next = 1'b1;
                            entry_vec_next.x = {{(CORDIC_W-DIFF_W-FRAC_W){px[DIFF_W-1]}},
                                                px, {FRAC_W{1'b0}}};
                            entry_vec_next.y = {{(CORDIC_W-DIFF_W-FRAC_W){py[DIFF_W-1]}},
                                                py, {FRAC_W{1'b0}}};
                            entry_vec_next.z = pz;
                            zero_next        = (dx == '0) && (dy == '0);
                            state_next       = ST_CORDIC;
                        end
                        ACT_START:
                        begin
                            if (!cal_active_reg)
                            begin
                                cal_active_next  = 1'b1;
                                min_x_next       = 16'sh7fff;
                                max_x_next       = -16'sh8000;
                                min_y_next       = 16'sh7fff;
                                max_y_next       = -16'sh8000;
                                last_result_next = STAT_NONE;
                            end
                        end
                        ACT_FINISH:
                        begin
                            if (cal_active_reg)
                            begin
                                cal_active_next = 1'b0;
                                if (span_small)
                                begin
                                    last_result_next = STAT_TOO_SMALL;
                                end
                                else
                                begin
                                    off_x_next       = adj_x[DIFF_W-1:1];
                                    off_y_next       = adj_y[DIFF_W-1:1];
                                    last_result_next = STAT_ACCEPTED;
                                end
                            end
                        end
                        ACT_ABORT:
                        begin
                            cal_active_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_CORDIC:
            begin
                if (post_valid)
                begin
                    last_heading_next  = post_heading;
                    last_cardinal_next = post_cardinal;
                    state_next         = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, off_y_reg, off_x_reg, span_val, last_result_reg,
                                     cal_active_reg, last_cardinal_reg, last_heading_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cal_active_reg    <= 1'b0;
            min_x_reg         <= '0;
            max_x_reg         <= '0;
            min_y_reg         <= '0;
            max_y_reg         <= '0;
            off_x_reg         <= '0;
            off_y_reg         <= '0;
            last_result_reg   <= STAT_NONE;
            last_heading_reg  <= '0;
            last_cardinal_reg <= '0;
            min_span_reg      <= MIN_SPAN_RESET;
            decl_reg          <= '0;
            entry_valid_reg   <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cal_active_reg    <= cal_active_next;
            min_x_reg         <= min_x_next;
            max_x_reg         <= max_x_next;
            min_y_reg         <= min_y_next;
            max_y_reg         <= max_y_next;
            off_x_reg         <= off_x_next;
            off_y_reg         <= off_y_next;
            last_result_reg   <= last_result_next;
            last_heading_reg  <= last_heading_next;
            last_cardinal_reg <= last_cardinal_next;
            min_span_reg      <= min_span_next;
            decl_reg          <= decl_next;
            entry_valid_reg   <= entry_valid_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        entry_vec_reg <= entry_vec_next;
        zero_reg      <= zero_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // chain of micro-rotation cells
    assign chain_vec[0]   = entry_vec_reg;
    assign chain_valid[0] = entry_valid_reg;

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        mhc_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1])
        );
    end

    // heading and cardinal from the final angle
    mhc_heading_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (chain_valid[ITERATIONS]),
        .angle       (chain_vec[ITERATIONS].z),
        .zero_vec    (zero_reg),
        .declination (decl_reg),
        .out_valid   (post_valid),
        .heading     (post_heading),
        .cardinal    (post_cardinal)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/mhc_cordic_cell.sv =====
// one vectoring CORDIC micro-rotation with its output register
// depends on mhc_pkg for the vector type and the step angle table
module mhc_cordic_cell
    import mhc_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cordic_vec_t in_vec,
    output logic        out_valid,
    output cordic_vec_t out_vec
);

    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [ANGLE_W-1:0]  step;
    cordic_vec_t                vec_next;
    logic                       valid_reg;
    cordic_vec_t                vec_reg;

    // shifted cross terms, arithmetic shift rounds toward minus infinity
    assign dx   = $signed(in_vec.y) >>> SHIFT;
    assign dy   = $signed(in_vec.x) >>> SHIFT;
    assign step = $signed(STEP_ANGLE[SHIFT]);

    // rotate toward the x axis
    always_comb
    begin
        if (in_vec.y[CORDIC_W-1])
        begin
            vec_next.x = $signed(in_vec.x) - dx;
            vec_next.y = $signed(in_vec.y) + dy;
            vec_next.z = $signed(in_vec.z) - step;
        end
        else
        begin
            vec_next.x = $signed(in_vec.x) + dx;
            vec_next.y = $signed(in_vec.y) - dy;
            vec_next.z = $signed(in_vec.z) + step;
        end
    end

    // valid travels with reset, payload without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== hw/rtl/mhc_heading_post.sv =====
// declination, wrap, rounding to whole degrees and eight-point index
// depends on mhc_pkg for widths and angle constants
module mhc_heading_post
    import mhc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic                      zero_vec,
    input  logic signed [8:0]         declination,
    output logic                      out_valid,
    output logic [8:0]                heading,
    output logic [2:0]                cardinal
);

    localparam logic signed [HEAD_W-1:0] FT  = HEAD_W'(FULL_TURN);
    localparam logic signed [HEAD_W-1:0] FT2 = HEAD_W'(2 * FULL_TURN);

    logic signed [ANGLE_W-1:0] angle_sel;
    logic signed [HEAD_W-1:0]  hsum;
    logic signed [HEAD_W-1:0]  hwrap;
    logic [TURN_W:0]           hround;
    logic [8:0]                deg_raw;
    logic [8:0]                deg;
    logic [9:0]                biased;
    logic [9:0]                folded;
    logic [2:0]                card;
    logic                      valid_reg;
    logic [8:0]                heading_reg;
    logic [2:0]                cardinal_reg;

    // a zero vector has no direction and reads as angle zero
    assign angle_sel = zero_vec ? '0 : angle;
    assign hsum = $signed({angle_sel[ANGLE_W-1], angle_sel})
                + $signed({{2{declination[8]}}, declination, 8'b0});

    // wrap into one full turn
    always_comb
    begin
        if (hsum < -FT)
        begin
            hwrap = hsum + FT2;
        end
        else if (hsum < 0)
        begin
            hwrap = hsum + FT;
        end
        else if (hsum >= FT)
        begin
            hwrap = hsum - FT;
        end
        else
        begin
            hwrap = hsum;
        end
    end

    // round to whole degrees, a full turn folds to north
    assign hround  = {1'b0, hwrap[TURN_W-1:0]} + (TURN_W+1)'(ROUND_HALF);
    assign deg_raw = hround[TURN_W-1:8];
    assign deg     = (deg_raw >= 9'(DEG_TURN)) ? 9'd0 : deg_raw;

    // sector index, each point spans 45 degrees centered on its direction
    assign biased = {1'b0, deg} + 10'(CARD_BIAS);
    assign folded = (biased >= 10'(DEG_TURN)) ? biased - 10'(DEG_TURN) : biased;

    always_comb
    begin
        card = 3'd0;
        for (int k = 1; k < CARD_POINTS; k++)
        begin
            if (folded >= 10'(CARD_SECTOR * k))
            begin
                card = 3'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg  <= deg;
        cardinal_reg <= card;
    end

    assign out_valid = valid_reg;
    assign heading   = heading_reg;
    assign cardinal  = cardinal_reg;

endmodule

// ===== hw/rtl/mhc_checker.sv =====
// port-level checker for the magnetometer heading block, bound to the top level
// depends on assert_macros.svh and mhc_pkg for the status codes
`include "assert_macros.svh"

module mhc_checker
    import mhc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // a stalled result keeps its data
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))

    // one request at a time: a taken request makes the block busy
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // while collecting, no calibration outcome can be pending
    `ASSERT_IMPLY(a_cal_status_clear, clk, rst_n, m_tvalid && m_tdata[12],
                  m_tdata[14:13] == STAT_NONE)

    // heading stays within one turn
    `ASSERT_IMPLY(a_heading_range, clk, rst_n, m_tvalid, m_tdata[8:0] < 9'd360)

endmodule

bind magnetometer_heading_hard_iron_cal mhc_checker u_mhc_checker (.*);
